[rtl/core/stbs_pkg.sv]
// Shared constants, codes and control types for the sorted table search block.
package stbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH = INDEX_WIDTH + 1;
   localparam int DATA_WIDTH  = 32;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic write;    // store the request word into the table
      logic start;    // capture key and open the search bounds
      logic issue;    // read the table at the midpoint
      logic step;     // narrow the bounds from the probe compare
      logic publish;  // load the result register
   } stbs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_empty;  // bounds have crossed
      logic key_equal;    // probed entry equals the key
      logic out_free;     // result register can take a word this cycle
   } stbs_status_type;

endpackage

[rtl/core/stbs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/stbs_ctrl.sv]
// Sequencer for loads and binary search probes.
module stbs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_operation,
   output logic                      req_stall,
   input  stbs_pkg::stbs_status_type status,
   output stbs_pkg::stbs_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_PROBE   = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == stbs_pkg::OP_LOAD) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (status.range_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.issue = 1'b1;
               state_in  = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
            state_in = status.key_equal ? ST_FINISH : ST_PROBE;
         end
         ST_FINISH: begin
            // hold until the result register frees up
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/stbs_dp.sv]
// Search datapath: count register, table, bounds, probe compare, result register.
module stbs_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [stbs_pkg::COUNT_WIDTH-1:0]      csr_write_data,
   input  logic [stbs_pkg::INDEX_WIDTH-1:0]      req_entry_index,
   input  logic signed [stbs_pkg::DATA_WIDTH-1:0] req_data_value,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [stbs_pkg::INDEX_WIDTH-1:0]      rsp_match_index,
   input  stbs_pkg::stbs_cmd_type                cmd,
   output stbs_pkg::stbs_status_type             status
);

   localparam int CW = stbs_pkg::COUNT_WIDTH;
   localparam int IW = stbs_pkg::INDEX_WIDTH;
   localparam int DW = stbs_pkg::DATA_WIDTH;

   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        lo_ff;
   logic [CW-1:0]        hi_ff;     // exclusive upper bound
   logic [IW-1:0]        mid_ff;
   logic signed [DW-1:0] key_ff;
   logic                 hit_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [IW-1:0]        rsp_match_index_ff;

   logic [CW-1:0]        limit;
   logic [CW:0]          bound_sum;
   logic [IW-1:0]        mid;
   logic [DW-1:0]        probe_raw;
   logic signed [DW-1:0] probe;
   logic                 key_less;

   // clamp the count to the table depth
   assign limit = (count_ff > CW'(stbs_pkg::TABLE_DEPTH)) ?
                  CW'(stbs_pkg::TABLE_DEPTH) : count_ff;

   // floor((lo + hi_inclusive) / 2) with hi_inclusive = hi - 1
   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid       = bound_sum[IW:1];

   stbs_ram #(
      .WIDTH(DW),
      .DEPTH(stbs_pkg::TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (cmd.write),
      .wr_addr(req_entry_index),
      .wr_data(req_data_value),
      .rd_en  (cmd.issue),
      .rd_addr(mid),
      .rd_data(probe_raw)
   );

   assign probe    = probe_raw;
   assign key_less = key_ff < probe;

   assign status.range_empty = lo_ff >= hi_ff;
   assign status.key_equal   = key_ff == probe;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_data_value;
         lo_ff  <= '0;
         hi_ff  <= limit;
         hit_ff <= 1'b0;
      end
      if (cmd.issue) begin
         mid_ff <= mid;
      end
      if (cmd.step) begin
         if (status.key_equal) begin
            hit_ff <= 1'b1;
         end else if (key_less) begin
            hi_ff <= {1'b0, mid_ff};
         end else begin
            lo_ff <= {1'b0, mid_ff} + CW'(1);
         end
      end
      if (cmd.publish) begin
         rsp_found_ff       <= hit_ff;
         rsp_match_index_ff <= hit_ff ? mid_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_match_index_ff;

endmodule

[rtl/core/sorted_table_binary_search.sv]
// Top level of the sorted table binary search block.
//
// Usage: the req channel carries one word per item: operation selects a load
// (entry_index, data_value written into the table) or a search (data_value is
// the key). A load gives no rsp word; a search gives exactly one rsp word with
// found and match_index (0 when the key is absent or the table is empty).
// csr_write_enable/csr_write_data set entries_in_use, the count of leading
// table entries that a search covers; counts above the depth clamp to it.
// Sequence: a load is written into the table when accepted. A search is
// accepted, then runs probes (registered table read, then compare), a bound
// check that sees the bounds crossed (skipped on a hit), and a publish step.
// Probes go one at a time through the single table read port.
// Items are handled one at a time; req_stall is low only while idle.
// Reset clears the count to 0, the controller and the rsp valid flag; table
// contents stay undefined until loaded. When rsp_stall holds a result, new
// loads and a new search are still accepted; that search waits to publish
// until the result register is taken.
module sorted_table_binary_search (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [stbs_pkg::COUNT_WIDTH-1:0]       csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic [stbs_pkg::INDEX_WIDTH-1:0]       req_entry_index,
   input  logic signed [stbs_pkg::DATA_WIDTH-1:0] req_data_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [stbs_pkg::INDEX_WIDTH-1:0]       rsp_match_index
);

   stbs_pkg::stbs_cmd_type    cmd;
   stbs_pkg::stbs_status_type status;

   // sequencer: accept, probe, compare, publish
   stbs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_operation),
      .req_stall    (req_stall),
      .status       (status),
      .cmd          (cmd)
   );

   // table, bounds and result register
   stbs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_entry_index (req_entry_index),
      .req_data_value  (req_data_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

[bench/tb_sorted_table_binary_search.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sorted table binary search block.
module tb_sorted_table_binary_search;

   localparam int CW = stbs_pkg::COUNT_WIDTH;
   localparam int IW = stbs_pkg::INDEX_WIDTH;
   localparam int DW = stbs_pkg::DATA_WIDTH;
   localparam int DEPTH = stbs_pkg::TABLE_DEPTH;

   localparam int CLOCK_HIGH     = 6;
   localparam int CLOCK_LOW      = 6;
   localparam int SETTLE_CYCLES  = 30;     // longer than the worst-case search
   localparam int HOLDOFF_CYCLES = 300;
   localparam int RANDOM_ITEMS   = 180;
   localparam int MIN_PHASES     = 4;
   localparam longint RUN_LIMIT  = 64'd7_200_000;   // run limit in ns, with a 12 ns clock period

   localparam logic signed [DW-1:0] DATA_MIN = 32'h8000_0000;
   localparam logic signed [DW-1:0] DATA_MAX = 32'h7FFF_FFFF;
   localparam logic signed [DW-1:0] DATA_NEG = 32'hFFFF_FFFF;

   typedef struct packed {
      logic          found;
      logic [IW-1:0] match_index;
   } search_word_type;

   typedef enum logic [1:0] {ROW_LOAD, ROW_SEARCH, ROW_COUNT} row_kind_type;

   // arg is the entry index for a load or search, the count for a count row;
   // typed rows carry their expected word, the rest go through the predictor
   typedef struct packed {
      row_kind_type   kind;
      logic [CW-1:0]  arg;
      logic [DW-1:0]  value;
      logic           typed;
      logic           found;
      logic [IW-1:0]  index;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // out of reset: count 0, nothing probed
      '{ROW_SEARCH, 11'd0,    32'h0000_0000, 1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'h3FF,  DATA_MAX,      1'b1, 1'b0, 10'd0},
      // five ascending entries spanning the value range
      '{ROW_LOAD,   11'd0,    DATA_MIN,      1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd1,    DATA_NEG,      1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd2,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd3,    32'h0000_0001, 1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd4,    DATA_MAX,      1'b0, 1'b0, 10'd0},
      // loaded but still an empty search range
      '{ROW_SEARCH, 11'd0,    DATA_MIN,      1'b1, 1'b0, 10'd0},
      '{ROW_COUNT,  11'd5,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'h155,  DATA_MIN,      1'b1, 1'b1, 10'd0},
      '{ROW_SEARCH, 11'h2AA,  DATA_MAX,      1'b1, 1'b1, 10'd4},
      '{ROW_SEARCH, 11'd0,    DATA_NEG,      1'b1, 1'b1, 10'd1},
      '{ROW_SEARCH, 11'd0,    32'h0000_0000, 1'b1, 1'b1, 10'd2},
      // absent keys between entries
      '{ROW_SEARCH, 11'd0,    32'h0000_0002, 1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    32'hFFFF_FFFE, 1'b1, 1'b0, 10'd0},
      // single-entry range
      '{ROW_COUNT,  11'd1,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    DATA_MIN,      1'b1, 1'b1, 10'd0},
      '{ROW_SEARCH, 11'd0,    DATA_MAX,      1'b1, 1'b0, 10'd0},
      // top index, then break the ordering of the range
      '{ROW_LOAD,   11'h3FF,  DATA_MAX,      1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd2,    32'h0000_0064, 1'b0, 1'b0, 10'd0},
      '{ROW_COUNT,  11'd5,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    32'h0000_0001, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    32'h0000_0064, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    DATA_MAX,      1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    DATA_MIN,      1'b0, 1'b0, 10'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CW-1:0]         csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_operation;
   logic [IW-1:0]         req_entry_index;
   logic signed [DW-1:0]  req_data_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_found;
   logic [IW-1:0]         rsp_match_index;

   // shadow of the block: table contents and search count
   logic signed [DW-1:0]  table_image [DEPTH];
   logic [CW-1:0]         count_image;
   search_word_type       pending_outcomes [$];

   int mismatch_count   = 0;
   int searches_sent    = 0;
   int hits_seen        = 0;
   int table_loads      = 0;
   int phases_run       = 0;
   int sender_idle_pct  = 0;
   int receiver_stall_pct = 0;
   bit holdoff_request  = 1'b0;
   int holdoff_left     = 0;

   sorted_table_binary_search dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_index  (rsp_match_index)
   );

   always begin
      #CLOCK_HIGH clock = 1'b1;
      #CLOCK_LOW  clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // count as the search sees it: values above the depth clamp to the depth
   function automatic int search_span();
      return (count_image > DEPTH) ? DEPTH : int'(count_image);
   endfunction

   // binary search over the shadow table, probing (lo+hi)/2 rounded down
   function automatic search_word_type search_outcome(input logic signed [DW-1:0] key);
      search_word_type outcome;
      int lo;
      int hi;
      int mid;
      outcome = '0;
      lo = 0;
      hi = search_span() - 1;
      while (lo <= hi && !outcome.found) begin
         mid = (lo + hi) / 2;
         if (key < table_image[mid]) hi = mid - 1;
         else if (key > table_image[mid]) lo = mid + 1;
         else begin
            outcome.found = 1'b1;
            outcome.match_index = mid[IW-1:0];
         end
      end
      return outcome;
   endfunction

   // mostly keys that sit in the range, then near misses, noise and extremes
   function automatic logic signed [DW-1:0] pick_key(input int span);
      int roll;
      int at;
      roll = $urandom_range(0, 99);
      at = (span > 0) ? $urandom_range(0, span - 1) : 0;
      if (span > 0 && roll < 55) return table_image[at];
      if (span > 0 && roll < 75)
         return roll[0] ? table_image[at] + 32'sd1 : table_image[at] - 32'sd1;
      if (roll < 88) return $urandom;
      case (roll % 4)
         0: return DATA_MIN;
         1: return DATA_MAX;
         2: return 32'sd0;
         default: return DATA_NEG;
      endcase
   endfunction

   function automatic void set_idle_mode(input int mode);
      case (mode % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
         default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
      endcase
   endfunction

   // random table index as a request field
   function automatic logic [IW-1:0] any_index();
      return IW'($urandom_range(0, DEPTH - 1));
   endfunction

   // offer one request word, hold it until accepted, then update the shadow
   task automatic offer_word(input logic op, input logic [IW-1:0] index,
                             input logic signed [DW-1:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= index;
      req_data_value  <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == stbs_pkg::OP_LOAD) begin
         table_image[index] = value;
         table_loads++;
      end else begin
         pending_outcomes.push_back(search_outcome(value));
         searches_sent++;
      end
   endtask

   // drop valid, drain every expected word, then let a trailing load finish
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CW-1:0] count);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      count_image = count;
      csr_write_enable <= 1'b0;
   endtask

   // load entries 0..n-1 in ascending order; dense steps allow duplicates
   task automatic load_sorted_prefix(input int n, input bit dense);
      longint step_max;
      longint room;
      longint v;
      logic signed [DW-1:0] word_value;
      step_max = dense ? 64'd3 : (64'hFFFF_FFFF / (n + 1));
      room = 64'hFFFF_FFFF - step_max * (n + 1);
      v = -64'sd2147483648 + (longint'($urandom) % (room + 1));
      for (int k = 0; k < n; k++) begin
         v = v + (dense ? $urandom_range(0, 3) : $urandom_range(1, 32'(step_max)));
         word_value = v[DW-1:0];
         if (k == 0 && $urandom_range(0, 3) == 0) word_value = DATA_MIN;
         if (k == n - 1 && $urandom_range(0, 3) == 0) word_value = DATA_MAX;
         offer_word(stbs_pkg::OP_LOAD, k[IW-1:0], word_value);
      end
   endtask

   // Receiver: random stalls per phase, or a counted hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left = holdoff_left - 1;
      end else if (holdoff_request) begin
         holdoff_request = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Checker: compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin : check_results
      search_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected (found %0b index %0d)",
                                      rsp_found, rsp_match_index));
         end else begin
            want = pending_outcomes.pop_front();
            if (want.found) hits_seen++;
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b", rsp_found, want.found));
            if (rsp_match_index !== want.match_index)
               report_mismatch($sformatf("match_index %0d, expected %0d",
                                         rsp_match_index, want.match_index));
         end
      end
   end

   // Stimulus: directed rows, a full-depth table, then random phases.
   initial begin : stimulus
      stim_row_type row;
      int random_items;
      int phase;
      int pick;
      int n;
      int words;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_operation    <= stbs_pkg::OP_LOAD;
      req_entry_index  <= '0;
      req_data_value   <= '0;
      count_image = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with no idling.
      set_idle_mode(0);
      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         case (row.kind)
            ROW_COUNT: begin
               write_count(row.arg);
            end
            ROW_LOAD: begin
               offer_word(stbs_pkg::OP_LOAD, row.arg[IW-1:0], row.value);
            end
            default: begin
               offer_word(stbs_pkg::OP_SEARCH, row.arg[IW-1:0], row.value);
               // the typed word stands in place of the predicted one
               if (row.typed) pending_outcomes[$] = {row.found, row.index};
            end
         endcase
      end

      // Fill the whole table in order, then search at full and clamped counts.
      load_sorted_prefix(DEPTH, 1'b0);
      write_count(CW'(DEPTH));
      repeat (40) offer_word(stbs_pkg::OP_SEARCH, any_index(), pick_key(search_span()));
      write_count({CW{1'b1}});
      repeat (20) offer_word(stbs_pkg::OP_SEARCH, any_index(), pick_key(search_span()));
      write_count(CW'(DEPTH + 1 + $urandom_range(0, DEPTH - 2)));
      repeat (10) offer_word(stbs_pkg::OP_SEARCH, any_index(), pick_key(search_span()));

      // Random phases: each sets a count, usually reloads a sorted range,
      // then mixes searches with stray loads that may break the ordering.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS || phase < MIN_PHASES) begin
         set_idle_mode(phase);
         pick = $urandom_range(0, 9);
         if (phase >= 2 && pick == 0) begin
            write_count('0);
         end else if (phase >= 2 && pick == 1) begin
            write_count(CW'(DEPTH + $urandom_range(0, DEPTH - 1)));
         end else if (phase >= 2 && pick == 2) begin
            write_count(CW'($urandom_range(49, DEPTH - 1)));
         end else begin
            n = $urandom_range(1, 48);
            write_count(CW'(n));
            load_sorted_prefix(n, $urandom_range(0, 2) == 0);
            random_items += n;
         end
         words = $urandom_range(20, 50);
         for (int k = 0; k < words; k++) begin
            // first phase: hold off the receiver while requests keep coming
            if (phase == 0 && k == words / 2) holdoff_request = 1'b1;
            // second phase: pause the sender until every result is back
            if (phase == 1 && k == words / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_outcomes.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 99) < 15)
               offer_word(stbs_pkg::OP_LOAD, any_index(), $urandom);
            else
               offer_word(stbs_pkg::OP_SEARCH, any_index(), pick_key(search_span()));
            random_items++;
         end
         phase++;
         phases_run = phase;
      end

      wait_for_results();
      $display("covered %0d searches (%0d hits) and %0d table loads over %0d random phases",
               searches_sent, hits_seen, table_loads, phases_run);
      $display("counts from empty to full and clamped depth, with sender gaps, stalls and a hold-off");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: end the run once the run limit is reached, as when results stop arriving.
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("timeout at %0t with %0d results outstanding", $time, pending_outcomes.size());
      $display("status: fail");
      $finish;
   end

endmodule
